/* rtl/core/tsns_pkg.sv */
// Shared types and constants of the timed strum note scheduler.
// No dependencies; used by every module of the core.
`default_nettype none

package tsns_pkg;

  // Operation codes carried in the op field of a command transaction.
  typedef enum logic [2:0] {
    OP_TICK          = 3'd0,
    OP_STRUM_BEGIN   = 3'd1,
    OP_STRUM_NOTE    = 3'd2,
    OP_RELEASE       = 3'd3,
    OP_CANCEL        = 3'd4,
    OP_CANCEL_ALL    = 3'd5
  } tsns_op_e;

  // Strum patterns.
  localparam logic [1:0] PAT_UP  = 2'd1;
  localparam logic [1:0] PAT_ALT = 2'd2;

  // Most notes played by one tick.
  localparam int MAX_OUT = 32;
  localparam int NOUT_W  = 6;

  // Reset seed of the humanising LFSR.
  localparam logic [15:0] LFSR_SEED = 16'hACE1;

  typedef struct packed {
    logic [2:0]  op;
    logic [7:0]  source_device;
    logic [15:0] source_key;
    logic [6:0]  note_number;
    logic [6:0]  note_velocity;
    logic [4:0]  midi_channel;
    logic [4:0]  note_count;
    logic [15:0] spacing_ms;
    logic [1:0]  pattern;
    logic [9:0]  humanize_ms;
    logic [15:0] release_ms;
    logic        sustain_flag;
  } tsns_in_t;

  typedef struct packed {
    logic [6:0]  out_note;
    logic [6:0]  out_velocity;
    logic [4:0]  out_channel;
    logic [7:0]  out_device;
    logic [15:0] out_key;
    logic        out_allow_sustain;
    logic        out_last;
  } tsns_out_t;

endpackage

`default_nettype wire

/* rtl/core/tsns_jitter.sv */
// Humanising jitter unit: 16-bit Fibonacci LFSR and the registered scaling multiply.
// Depends on tsns_pkg for the seed.
`default_nettype none

module tsns_jitter
  import tsns_pkg::*;
(
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        step_i,
  input  wire logic        mul_i,
  input  wire logic [9:0]  hum_i,
  output logic      [10:0] jit_o
);

  logic [15:0] lfsr_q;
  logic [15:0] lfsr_d;
  logic [26:0] prod_q;
  logic        fb;

  // Taps 16, 14, 13 and 11, shifting towards bit 0.
  assign fb     = lfsr_q[0] ^ lfsr_q[2] ^ lfsr_q[3] ^ lfsr_q[5];
  assign lfsr_d = {fb, lfsr_q[15:1]};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      lfsr_q <= LFSR_SEED;
    end else if (step_i) begin
      lfsr_q <= lfsr_d;
    end
  end

  // The product times (2h+1) scaled down by 2^16 gives a value in [0, 2h].
  always_ff @(posedge clk_i) begin
    if (mul_i) begin
      prod_q <= 27'(lfsr_q) * 27'({hum_i, 1'b1});
    end
  end

  assign jit_o = prod_q[26:16];

endmodule

`default_nettype wire

/* rtl/core/timed_strum_note_scheduler_core.sv */
// Top level of the timed strum note scheduler: sequencer, note queue and release table.
// Depends on tsns_pkg and instantiates tsns_jitter.
`default_nettype none

// Channel      Direction  Handshake                      Payload
// command      in         start high while busy is low   cmd_i   (tsns_in_t)
// result       out        out_valid_o, one cycle only    result_o (tsns_out_t)
//
// A command transaction is taken at a rising edge with start high and busy low.
// Strum_begin, cancel_all and most release transactions complete without leaving idle.
// A tick walks the release table slot by slot in ST_EXPIRE and then the note queue,
// each queued note through ST_QMT and ST_QEV, and closes through ST_QMT and ST_QEND.
// A cancel, or a zero-length release without sustain, walks the queue the same way.
// The strum_note that completes a chord writes the chord note by note, each through ST_CSTEP, ST_CMUL and ST_CWR.
// The receiver cannot stall: each result is shown for exactly one cycle.
// Reset clears the clock, queue fill count, release valid bits and the open strum.

module timed_strum_note_scheduler_core
  import tsns_pkg::*;
#(
  parameter int QUEUE_DEPTH     = 32,
  parameter int RELEASE_DEPTH   = 8,
  parameter int MAX_CHORD_NOTES = 16,
  parameter int TIME_BITS       = 32
) (
  input  wire logic      clk_i,
  input  wire logic      rst_ni,
  input  wire logic      start,
  output logic           busy,
  input  wire tsns_in_t  cmd_i,
  output logic           out_valid_o,
  output tsns_out_t      result_o
);

  localparam int QI_W = $clog2(QUEUE_DEPTH + 1);
  localparam int QA_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int RA_W = (RELEASE_DEPTH > 1) ? $clog2(RELEASE_DEPTH) : 1;
  localparam int NC_W = $clog2(MAX_CHORD_NOTES + 1);
  localparam int NA_W = (MAX_CHORD_NOTES > 1) ? $clog2(MAX_CHORD_NOTES) : 1;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_EXPIRE,
    ST_QMT,
    ST_QEV,
    ST_QEND,
    ST_CSTEP,
    ST_CMUL,
    ST_CWR
  } state_e;

  // Modular time order: a is at or before b.
  function automatic logic time_le(input logic [TIME_BITS-1:0] a,
                                   input logic [TIME_BITS-1:0] b);
    logic [TIME_BITS-1:0] d;
    d = b - a;
    return !d[TIME_BITS-1];
  endfunction

  state_e               state_q;
  logic [TIME_BITS-1:0] ms_q;
  logic                 auto_down_q;
  logic [QI_W-1:0]      qcount_q;

  // Release table: one window per source, kept as its expiry time.
  logic [RELEASE_DEPTH-1:0] rel_valid_q;
  logic [RELEASE_DEPTH-1:0] rel_kill_q;
  logic [RELEASE_DEPTH-1:0] rel_sus_q;
  logic [23:0]              rel_src_q [RELEASE_DEPTH];
  logic [TIME_BITS-1:0]     rel_exp_q [RELEASE_DEPTH];

  // Open strum.
  logic                 sp_open_q, sp_up_q, sp_sus_q;
  logic [NC_W-1:0]      sp_need_q, sp_got_q, pos_q;
  logic [9:0]           sp_hum_q;
  logic [4:0]           sp_ch_q;
  logic [15:0]          sp_spacing_q;
  logic [23:0]          sp_src_q;
  logic [TIME_BITS-1:0] tacc_q;
  logic [6:0]           sp_note_q [MAX_CHORD_NOTES];
  logic [6:0]           sp_vel_q  [MAX_CHORD_NOTES];

  // Queue walk.
  logic [QI_W-1:0]      i_q, i_d, w_q;
  logic [RA_W-1:0]      r_q, f_q;
  logic                 purge_mode_q;
  logic [23:0]          purge_src_q;
  logic                 hit_q, killhit_q;
  logic [TIME_BITS-1:0] ent_time_q;
  logic [19:0]          ent_info_q;
  logic [23:0]          ent_src_q;
  logic [NOUT_W-1:0]    nout_q;
  logic                 pend_valid_q;
  tsns_out_t            pend_q;
  tsns_out_t            pend_last;
  logic                 out_valid_q;
  tsns_out_t            out_q;

  // Queue memory.
  logic [TIME_BITS-1:0] qtime_mem [QUEUE_DEPTH];
  logic [19:0]          qinfo_mem [QUEUE_DEPTH];
  logic [23:0]          qsrc_mem  [QUEUE_DEPTH];
  logic [TIME_BITS-1:0] qrd_time_q;
  logic [19:0]          qrd_info_q;
  logic [23:0]          qrd_src_q;
  logic                 q_we;
  logic [QA_W-1:0]      q_waddr;
  logic [TIME_BITS-1:0] q_wtime;
  logic [19:0]          q_winfo;
  logic [23:0]          q_wsrc;

  logic                 accept;
  logic [23:0]          cmd_src;
  logic [23:0]          match_key;
  logic                 match_hit, free_hit;
  logic [RA_W-1:0]      match_idx, free_idx, rel_idx;
  logic [TIME_BITS-1:0] rel_exp_rd;
  logic                 drop, emit, keep;
  logic                 le_exp, le_now;
  logic [NC_W-1:0]      cnt_sat;
  logic [NC_W-1:0]      a_pos;
  logic [TIME_BITS-1:0] note_time;
  logic                 room;
  logic                 jit_step, jit_mul;
  logic [10:0]          jit;
  tsns_out_t            ent_out;

  assign accept  = start && !busy;
  assign busy    = (state_q != ST_IDLE);
  assign cmd_src = {cmd_i.source_device, cmd_i.source_key};
  assign room    = (qcount_q < QI_W'(QUEUE_DEPTH));

  // Source lookup in the release table, and the first free slot.
  always_comb begin
    match_key = (state_q == ST_QMT) ? qrd_src_q : cmd_src;
    match_hit = 1'b0;
    match_idx = '0;
    free_hit  = 1'b0;
    free_idx  = '0;
    for (int r = 0; r < RELEASE_DEPTH; r++) begin
      if (!match_hit && (rel_valid_q[r] || rel_kill_q[r]) && rel_src_q[r] == match_key) begin
        match_hit = 1'b1;
        match_idx = RA_W'(r);
      end
      if (!free_hit && !rel_valid_q[r]) begin
        free_hit = 1'b1;
        free_idx = RA_W'(r);
      end
    end
  end

  assign rel_idx    = (state_q == ST_EXPIRE) ? r_q : f_q;
  assign rel_exp_rd = rel_exp_q[rel_idx];

  // Decision for the queued note under evaluation.
  assign le_exp = time_le(ent_time_q, rel_exp_rd);
  assign le_now = time_le(ent_time_q, ms_q);
  assign drop   = purge_mode_q ? (ent_src_q == purge_src_q)
                               : (killhit_q || (hit_q && !rel_sus_q[f_q] && !le_exp));
  assign emit   = !purge_mode_q && !drop && (nout_q < NOUT_W'(MAX_OUT)) && le_now;
  assign keep   = !drop && !emit;

  always_comb begin
    ent_out.out_note          = ent_info_q[6:0];
    ent_out.out_velocity      = ent_info_q[13:7];
    ent_out.out_channel       = ent_info_q[18:14];
    ent_out.out_device        = ent_src_q[23:16];
    ent_out.out_key           = ent_src_q[15:0];
    ent_out.out_allow_sustain = ent_info_q[19];
    ent_out.out_last          = 1'b0;
  end

  // The held note marked as the last one of the tick.
  always_comb begin
    pend_last          = pend_q;
    pend_last.out_last = 1'b1;
  end

  // Chord commit: position order, with the buffer read reversed for an upward strum.
  always_comb begin
    if (int'(cmd_i.note_count) > MAX_CHORD_NOTES) begin
      cnt_sat = NC_W'(MAX_CHORD_NOTES);
    end else begin
      cnt_sat = NC_W'(cmd_i.note_count);
    end
  end

  assign a_pos     = sp_up_q ? (sp_need_q - NC_W'(1) - pos_q) : pos_q;
  assign note_time = (sp_hum_q != 10'd0)
                     ? (tacc_q + TIME_BITS'(jit) - TIME_BITS'(sp_hum_q)) : tacc_q;
  assign jit_step  = (state_q == ST_CSTEP) && (sp_hum_q != 10'd0);
  assign jit_mul   = (state_q == ST_CMUL);

  tsns_jitter u_jitter (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .step_i (jit_step),
    .mul_i  (jit_mul),
    .hum_i  (sp_hum_q),
    .jit_o  (jit)
  );

  // Queue read pointer runs one step ahead so that read data is ready on entry.
  always_comb begin
    i_d = i_q;
    if (state_q == ST_IDLE || state_q == ST_EXPIRE) begin
      i_d = '0;
    end else if (state_q == ST_QEV) begin
      i_d = i_q + QI_W'(1);
    end
  end

  // Queue write port: compaction during a walk, appends during a commit.
  always_comb begin
    q_we    = 1'b0;
    q_waddr = w_q[QA_W-1:0];
    q_wtime = ent_time_q;
    q_winfo = ent_info_q;
    q_wsrc  = ent_src_q;
    if (state_q == ST_QEV) begin
      q_we = keep;
    end else if (state_q == ST_CWR) begin
      q_we    = room;
      q_waddr = qcount_q[QA_W-1:0];
      q_wtime = note_time;
      q_winfo = {sp_sus_q, sp_ch_q, sp_vel_q[a_pos[NA_W-1:0]], sp_note_q[a_pos[NA_W-1:0]]};
      q_wsrc  = sp_src_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (q_we) begin
      qtime_mem[q_waddr] <= q_wtime;
      qinfo_mem[q_waddr] <= q_winfo;
      qsrc_mem[q_waddr]  <= q_wsrc;
    end
    qrd_time_q <= qtime_mem[i_d[QA_W-1:0]];
    qrd_info_q <= qinfo_mem[i_d[QA_W-1:0]];
    qrd_src_q  <= qsrc_mem[i_d[QA_W-1:0]];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      i_q <= '0;
    end else begin
      i_q <= i_d;
    end
  end

  // Sequencer, tables and registered result.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= ST_IDLE;
      ms_q         <= '0;
      auto_down_q  <= 1'b0;
      qcount_q     <= '0;
      rel_valid_q  <= '0;
      rel_kill_q   <= '0;
      sp_open_q    <= 1'b0;
      sp_got_q     <= '0;
      pend_valid_q <= 1'b0;
      out_valid_q  <= 1'b0;
      nout_q       <= '0;
    end else begin
      unique case (state_q)
        ST_IDLE: begin
          out_valid_q <= 1'b0;
          if (accept) begin
            unique case (cmd_i.op)
              OP_TICK: begin
                ms_q         <= ms_q + TIME_BITS'(1);
                r_q          <= '0;
                w_q          <= '0;
                nout_q       <= '0;
                purge_mode_q <= 1'b0;
                state_q      <= ST_EXPIRE;
              end
              OP_STRUM_BEGIN: begin
                sp_up_q <= (cmd_i.pattern == PAT_UP) ||
                           (cmd_i.pattern == PAT_ALT && !auto_down_q);
                if (cmd_i.pattern == PAT_ALT) begin
                  auto_down_q <= !auto_down_q;
                end
                sp_open_q    <= (cnt_sat != '0);
                sp_need_q    <= cnt_sat;
                sp_got_q     <= '0;
                sp_spacing_q <= cmd_i.spacing_ms;
                sp_hum_q     <= cmd_i.humanize_ms;
                sp_ch_q      <= cmd_i.midi_channel;
                sp_src_q     <= cmd_src;
                sp_sus_q     <= cmd_i.sustain_flag;
                tacc_q       <= ms_q;
              end
              OP_STRUM_NOTE: begin
                if (sp_open_q && sp_got_q < sp_need_q) begin
                  sp_note_q[sp_got_q[NA_W-1:0]] <= cmd_i.note_number;
                  sp_vel_q[sp_got_q[NA_W-1:0]]  <= cmd_i.note_velocity;
                  sp_got_q <= sp_got_q + NC_W'(1);
                  if (sp_got_q + NC_W'(1) == sp_need_q) begin
                    sp_open_q <= 1'b0;
                    pos_q     <= '0;
                    state_q   <= ST_CSTEP;
                  end
                end
              end
              OP_RELEASE: begin
                if (cmd_i.release_ms != 16'd0) begin
                  if (match_hit || free_hit) begin
                    rel_valid_q[match_hit ? match_idx : free_idx] <= 1'b1;
                    rel_sus_q[match_hit ? match_idx : free_idx]   <= cmd_i.sustain_flag;
                    rel_src_q[match_hit ? match_idx : free_idx]   <= cmd_src;
                    rel_exp_q[match_hit ? match_idx : free_idx]   <=
                      ms_q + TIME_BITS'(cmd_i.release_ms);
                  end
                end else begin
                  if (match_hit) begin
                    rel_valid_q[match_idx] <= 1'b0;
                  end
                  if (!cmd_i.sustain_flag) begin
                    purge_mode_q <= 1'b1;
                    purge_src_q  <= cmd_src;
                    w_q          <= '0;
                    state_q      <= ST_QMT;
                  end
                end
              end
              OP_CANCEL: begin
                if (match_hit) begin
                  rel_valid_q[match_idx] <= 1'b0;
                end
                purge_mode_q <= 1'b1;
                purge_src_q  <= cmd_src;
                w_q          <= '0;
                state_q      <= ST_QMT;
              end
              OP_CANCEL_ALL: begin
                qcount_q    <= '0;
                rel_valid_q <= '0;
                sp_open_q   <= 1'b0;
              end
              default: begin
              end
            endcase
          end
        end

        // Expire windows; a window without sustain marks its source for dropping.
        ST_EXPIRE: begin
          out_valid_q <= 1'b0;
          if (rel_valid_q[r_q] && time_le(rel_exp_rd, ms_q)) begin
            rel_valid_q[r_q] <= 1'b0;
            rel_kill_q[r_q]  <= !rel_sus_q[r_q];
          end
          if (r_q == RA_W'(RELEASE_DEPTH - 1)) begin
            state_q <= ST_QMT;
          end else begin
            r_q <= r_q + RA_W'(1);
          end
        end

        ST_QMT: begin
          out_valid_q <= 1'b0;
          if (i_q == qcount_q) begin
            state_q <= ST_QEND;
          end else begin
            ent_time_q <= qrd_time_q;
            ent_info_q <= qrd_info_q;
            ent_src_q  <= qrd_src_q;
            hit_q      <= match_hit;
            killhit_q  <= match_hit && rel_kill_q[match_idx];
            f_q        <= match_idx;
            state_q    <= ST_QEV;
          end
        end

        // A played note waits in pend_q so that the final one can carry out_last.
        ST_QEV: begin
          if (keep) begin
            w_q <= w_q + QI_W'(1);
          end
          out_valid_q <= emit && pend_valid_q;
          if (emit) begin
            out_q        <= pend_q;
            pend_q       <= ent_out;
            pend_valid_q <= 1'b1;
            nout_q       <= nout_q + NOUT_W'(1);
          end
          state_q <= ST_QMT;
        end

        ST_QEND: begin
          qcount_q    <= w_q;
          rel_kill_q  <= '0;
          out_valid_q <= pend_valid_q;
          if (pend_valid_q) begin
            out_q        <= pend_last;
            pend_valid_q <= 1'b0;
          end
          state_q <= ST_IDLE;
        end

        ST_CSTEP: begin
          out_valid_q <= 1'b0;
          state_q     <= ST_CMUL;
        end

        ST_CMUL: begin
          out_valid_q <= 1'b0;
          state_q     <= ST_CWR;
        end

        ST_CWR: begin
          out_valid_q <= 1'b0;
          if (room) begin
            qcount_q <= qcount_q + QI_W'(1);
          end
          tacc_q <= tacc_q + TIME_BITS'(sp_spacing_q);
          pos_q  <= pos_q + NC_W'(1);
          if (pos_q + NC_W'(1) == sp_need_q) begin
            state_q <= ST_IDLE;
          end else begin
            state_q <= ST_CSTEP;
          end
        end

        default: begin
          out_valid_q <= 1'b0;
          state_q     <= ST_IDLE;
        end
      endcase
    end
  end

  assign out_valid_o = out_valid_q;
  assign result_o    = out_q;

`ifndef NO_ASSERTIONS
  a_tick_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept && cmd_i.op == OP_TICK |=> busy)
    else $error("tick transaction did not start a walk");

  a_out_in_walk: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> $past(state_q == ST_QEV || state_q == ST_QEND))
    else $error("result shown outside a queue walk");

  a_qcount_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    qcount_q <= QI_W'(QUEUE_DEPTH))
    else $error("queue fill count beyond depth");

  a_kill_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == ST_IDLE |-> rel_kill_q == '0)
    else $error("expired source marks left after a walk");

  a_nout_limit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    nout_q <= NOUT_W'(MAX_OUT))
    else $error("too many notes played in one tick");
`endif

endmodule

`default_nettype wire
